// ----- sv/ihct_pkg.sv -----
package ihct_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DECAY_PERIOD        = 2'd0;
  localparam logic [1:0] CFG_READ_LATENCY_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_WRITE_LATENCY_LIMIT = 2'd2;
  localparam logic [1:0] CFG_ERROR_SCORE_LIMIT   = 2'd3;

  localparam int LIMIT_W = 31;
  localparam int LEVEL_W = 11;
  // latency is turned into a congestion drop by dropping this many low bits
  localparam int DROP_SHIFT = 10;
  // score decay multiplies by (2^SCALE_SHIFT - 1) / 2^SCALE_SHIFT
  localparam int SCALE_SHIFT = 7;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_DECAY,
    SEQ_DONE
  } seq_state_t;

endpackage

// ----- sv/io_health_and_congestion_tracker.sv -----
// A word accepted into the input register goes to the result register on commit.
// Throughput: one word per cycle unless out_stall or the sequencer holds it.
// A completion that finds the counter above a lowered decay period is held while
// the sequencer divides, decays the score (zero in under 2700 steps) and finishes.
// Reset (rst, synchronous): config, valids, counter, score, level and stamp clear.
module io_health_and_congestion_tracker
  import ihct_pkg::*;
#(
  parameter int CONGESTION_MAX     = 1024,
  parameter int ERROR_WEIGHT_SHIFT = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_en,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  // event channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic                      is_write,
  input  logic [31:0]               submit_us,
  input  logic [31:0]               now_us,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [LEVEL_W-1:0] congestion_level,
  output logic [31:0]               error_score,
  output logic                      over_limit,
  output logic [31:0]               last_congested_us
);

  // Level needs to reach -CONGESTION_MAX
  localparam int CW = $clog2(CONGESTION_MAX) + 1;
  localparam logic signed [31:0] CMAX_S     = CONGESTION_MAX;
  localparam logic [31:0]        ERR_WEIGHT = 32'd1 << ERROR_WEIGHT_SHIFT;

  // Configuration registers
  logic [31:0]        decay_period;
  logic [LIMIT_W-1:0] read_latency_limit;
  logic [LIMIT_W-1:0] write_latency_limit;
  logic [31:0]        error_score_limit;

  // Tracker state
  logic [31:0]          completion_count, completion_count_next;
  logic [31:0]          error_accum, error_accum_next;
  logic signed [CW-1:0] congestion, congestion_next;
  logic [31:0]          congested_stamp, congested_stamp_next;

  // Input register
  logic        s1_valid;
  logic        s1_func;
  logic        s1_is_write;
  logic [31:0] s1_submit_us;
  logic [31:0] s1_now_us;

  // Renormalization sequencer: divider and decay stepper
  seq_state_t  state, state_next;
  logic [31:0] div_q, div_q_next;
  logic [31:0] div_r, div_r_next;
  logic [4:0]  div_cnt, div_cnt_next;
  logic [31:0] decay_steps, decay_steps_next;

  // Datapath
  logic [LIMIT_W-1:0] thr;
  logic [31:0]        diff;
  logic               timed;
  logic               lat_over;
  logic signed [31:0] cong_w, room, drop, drop_c, cong_upd;
  logic [38:0]        acc_x127;
  logic [31:0]        scaled;
  logic [31:0]        count_inc;
  logic               abnormal;
  logic [31:0]        accum_err;
  logic               err_over;
  logic [32:0]        rem_sh, rem_sub;
  logic               fits;
  logic [31:0]        rem_new;
  logic               slot_free;
  logic               commit;
  logic               in_acc;
  logic signed [31:0] level_w;

  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    // latency check; untimed or disabled completions skip it entirely
    thr      = s1_is_write ? write_latency_limit : read_latency_limit;
    diff     = s1_now_us - s1_submit_us;
    timed    = (thr != '0) && (s1_submit_us != '0);
    lat_over = timed && !diff[31] && (diff[30:0] > thr);
    cong_w   = 32'(congestion);
    room     = CMAX_S + cong_w;
    drop     = signed'({{DROP_SHIFT{1'b0}}, diff[31:DROP_SHIFT]});
    drop_c   = (drop > room) ? room : drop;
    if (lat_over) begin
      cong_upd = cong_w - drop_c;
    end else if (timed && (cong_w < 0)) begin
      cong_upd = cong_w + 32'sd1;
    end else begin
      cong_upd = cong_w;
    end

    // score decay by 127/128, rounded down
    acc_x127 = {error_accum, {SCALE_SHIFT{1'b0}}} - {{SCALE_SHIFT{1'b0}}, error_accum};
    scaled   = acc_x127[38:SCALE_SHIFT];

    // counter is beyond a lowered period and needs whole periods removed
    count_inc = completion_count + 32'd1;
    abnormal  = (decay_period != '0) && (completion_count > decay_period) &&
                (completion_count != '1);

    // error report, saturating
    accum_err = (error_accum > ~ERR_WEIGHT) ? '1 : error_accum + ERR_WEIGHT;
    err_over  = accum_err >= error_score_limit;

    // one restoring division step
    rem_sh  = {div_r, div_q[31]};
    fits    = rem_sh >= {1'b0, decay_period};
    rem_sub = rem_sh - {1'b0, decay_period};
    rem_new = fits ? rem_sub[31:0] : rem_sh[31:0];

    commit = s1_valid && slot_free &&
             (((state == SEQ_IDLE) && !(!s1_func && abnormal)) || (state == SEQ_DONE));

    state_next            = state;
    div_q_next            = div_q;
    div_r_next            = div_r;
    div_cnt_next          = div_cnt;
    decay_steps_next      = decay_steps;
    completion_count_next = completion_count;
    error_accum_next      = error_accum;
    congestion_next       = congestion;
    congested_stamp_next  = congested_stamp;

    unique case (state)
      SEQ_IDLE: begin
        if (s1_valid && !s1_func && abnormal) begin
          state_next   = SEQ_DIV;
          div_q_next   = completion_count;
          div_r_next   = '0;
          div_cnt_next = '1;
        end
      end
      SEQ_DIV: begin
        div_r_next   = rem_new;
        div_q_next   = {div_q[30:0], fits};
        div_cnt_next = div_cnt - 5'd1;
        if (div_cnt == '0) begin
          // quotient is the period count to remove, remainder + 1 the new count
          state_next            = SEQ_DECAY;
          completion_count_next = rem_new + 32'd1;
          decay_steps_next      = {div_q[30:0], fits};
        end
      end
      SEQ_DECAY: begin
        if ((decay_steps != '0) && (error_accum != '0)) begin
          error_accum_next = scaled;
          decay_steps_next = decay_steps - 32'd1;
        end else begin
          state_next = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (commit) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase

    if (commit) begin
      if (s1_func) begin
        error_accum_next = accum_err;
      end else begin
        congestion_next = cong_upd[CW-1:0];
        if (lat_over) begin
          congested_stamp_next = s1_now_us;
        end
        // counting was already settled by the sequencer when it ran
        if ((state != SEQ_DONE) && (decay_period != '0)) begin
          if (count_inc <= decay_period) begin
            completion_count_next = count_inc;
          end else begin
            completion_count_next = 32'd1;
            error_accum_next      = scaled;
          end
        end
      end
    end

    level_w  = 32'(congestion_next);
    in_stall = s1_valid && !commit;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period        <= '0;
      read_latency_limit  <= '0;
      write_latency_limit <= '0;
      error_score_limit   <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_DECAY_PERIOD:        decay_period        <= cfg_data;
        CFG_READ_LATENCY_LIMIT:  read_latency_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_WRITE_LATENCY_LIMIT: write_latency_limit <= cfg_data[LIMIT_W-1:0];
        CFG_ERROR_SCORE_LIMIT:   error_score_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // tracker state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= SEQ_IDLE;
      completion_count <= '0;
      error_accum      <= '0;
      congestion       <= '0;
      congested_stamp  <= '0;
    end else begin
      state            <= state_next;
      completion_count <= completion_count_next;
      error_accum      <= error_accum_next;
      congestion       <= congestion_next;
      congested_stamp  <= congested_stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    div_q       <= div_q_next;
    div_r       <= div_r_next;
    div_cnt     <= div_cnt_next;
    decay_steps <= decay_steps_next;
  end

  // input register: load on accept, drop when its result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func      <= func;
      s1_is_write  <= is_write;
      s1_submit_us <= submit_us;
      s1_now_us    <= now_us;
    end
  end

  // result register: hold while stalled, advance on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      congestion_level  <= level_w[LEVEL_W-1:0];
      error_score       <= error_accum_next;
      over_limit        <= s1_func && err_over;
      last_congested_us <= congested_stamp_next;
    end
  end

  // the sequencer only runs on a held completion
  a_seq_has_item : assert property (@(posedge clk) disable iff (rst)
    (state != SEQ_IDLE) |-> (s1_valid && !s1_func))
    else $error("sequencer active without a held completion");

  // congestion level stays within its floor and zero
  a_level_range : assert property (@(posedge clk) disable iff (rst)
    (32'(congestion) >= -CMAX_S) && (32'(congestion) <= 32'sd0))
    else $error("congestion level out of range");

  // a completion never reports over limit
  a_completion_flag : assert property (@(posedge clk) disable iff (rst)
    (commit && !s1_func) |=> !over_limit)
    else $error("over limit flagged on a completion");

endmodule
